// ===== rtl/sacf_pkg.sv =====
// Shared types and constants for the set-associative FIFO-replacement tag store.
// No dependencies; every other file of the block but sacf_ram uses this package.
package sacf_pkg;

  // Geometry of the tag store.
  localparam int SETS     = 256;
  localparam int WAYS     = 8;
  localparam int TAG_BITS = 24;

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_W = $clog2(WAYS + 1);

  // Field widths fixed by the interface.
  localparam int IDX_FIELD_W  = 8;
  localparam int TAG_FIELD_W  = 24;
  localparam int KIND_FIELD_W = 2;
  localparam int WAY_FIELD_W  = 3;
  localparam int CFG_W        = 4;

  // Associativity after reset.
  localparam logic [CFG_W-1:0] WAYS_RESET = 4'd8;

  // Outcome of one access.
  typedef enum logic [KIND_FIELD_W-1:0] {
    KIND_HIT   = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_EVICT = 2'd2
  } kind_t;

  // One memory row: all tags of a set plus its fill count and FIFO pointer.
  typedef struct packed {
    logic [WAYS-1:0][TAG_BITS-1:0] tags;
    logic [FILL_W-1:0]             fill;
    logic [WAY_W-1:0]              oldest;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // Decision handed from the lookup logic to the top level.
  typedef struct packed {
    kind_t               kind;
    logic [WAY_W-1:0]    way;
    logic [TAG_BITS-1:0] evicted;
    logic                wr;
  } lk_result_t;

endpackage

// ===== rtl/sacf_if.sv =====
// Valid/ready channel interfaces for requests and results of the tag store.
// Depends on sacf_pkg for the field widths.
interface sacf_req_if;
  logic                                valid;
  logic                                ready;
  logic [sacf_pkg::IDX_FIELD_W-1:0]    set_index;
  logic [sacf_pkg::TAG_FIELD_W-1:0]    access_tag;

  modport source (output valid, output set_index, output access_tag, input ready);
  modport sink   (input valid, input set_index, input access_tag, output ready);
endinterface

interface sacf_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [sacf_pkg::KIND_FIELD_W-1:0]   access_kind;
  logic [sacf_pkg::WAY_FIELD_W-1:0]    way_used;
  logic [sacf_pkg::TAG_FIELD_W-1:0]    evicted_tag;

  modport source (output valid, output access_kind, output way_used, output evicted_tag,
                  input ready);
  modport sink   (input valid, input access_kind, input way_used, input evicted_tag,
                  output ready);
endinterface

// ===== rtl/sacf_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sacf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sacf_lookup.sv =====
// Tag compare and FIFO replacement decision for one set row.
// Depends on sacf_pkg for the row layout and the result struct.
module sacf_lookup (
  input  sacf_pkg::row_t                        row,
  input  logic                                  row_ok,
  input  logic [sacf_pkg::TAG_BITS-1:0]         tag,
  input  logic [sacf_pkg::CFG_W-1:0]            ways_cfg,
  output sacf_pkg::lk_result_t                  res,
  output sacf_pkg::row_t                        new_row
);
  import sacf_pkg::*;

  logic [FILL_W-1:0] fill;
  logic [WAY_W-1:0]  oldest;
  logic [FILL_W-1:0] eff_ways;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  ev_way;
  logic [FILL_W-1:0] ev_next;

  // A set that was never written is empty with its pointer at way zero.
  assign fill   = row_ok ? row.fill   : '0;
  assign oldest = row_ok ? row.oldest : '0;

  // Associativity in force: zero acts as one, anything above WAYS as WAYS.
  always_comb begin
    if (ways_cfg == '0) begin
      eff_ways = FILL_W'(1);
    end else if ((CFG_W + 6)'(ways_cfg) > (CFG_W + 6)'(WAYS)) begin
      eff_ways = FILL_W'(WAYS);
    end else begin
      eff_ways = FILL_W'(ways_cfg);
    end
  end

  // Parallel compare over the valid ways; the lowest matching way wins.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if ((FILL_W'(w) < fill) && (row.tags[w] == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // Victim is the FIFO pointer, wrapped to way zero if it lies past the valid ways.
  always_comb begin
    if (FILL_W'(oldest) >= fill) begin
      ev_way = '0;
    end else begin
      ev_way = oldest;
    end
    ev_next = FILL_W'(ev_way) + FILL_W'(1);
    if (ev_next == fill) begin
      ev_next = '0;
    end
  end

  // Decision and the row to write back.
  always_comb begin
    new_row        = row;
    new_row.fill   = fill;
    new_row.oldest = oldest;
    res.kind       = KIND_HIT;
    res.way        = hit_way;
    res.evicted    = '0;
    res.wr         = 1'b0;
    if (!hit) begin
      res.wr = 1'b1;
      if (fill < eff_ways) begin
        res.kind                         = KIND_FILL;
        res.way                          = fill[WAY_W-1:0];
        new_row.tags[fill[WAY_W-1:0]]    = tag;
        new_row.fill                     = fill + FILL_W'(1);
      end else begin
        res.kind              = KIND_EVICT;
        res.way               = ev_way;
        res.evicted           = row.tags[ev_way];
        new_row.tags[ev_way]  = tag;
        new_row.oldest        = ev_next[WAY_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/set_assoc_cache_fifo_lookup.sv =====
// Pipeline: an accepted request is registered into the lookup stage while its row is read,
// and the lookup result is registered into the output register.
// Throughput: one request per cycle while results are taken; a request to the set written
// in the cycle before takes the row from a forwarding register, so there is no bubble.
// The single row memory (one read and one write per cycle) sets that figure.
// Reset: per-set valid flags clear at once (all sets empty, no sweep); the associativity is 8.
module set_assoc_cache_fifo_lookup (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [sacf_pkg::CFG_W-1:0]  cfg_wr_data,
  sacf_req_if.sink                    in_ch,
  sacf_rsp_if.source                  out_ch
);
  import sacf_pkg::*;

  logic [CFG_W-1:0]    ways_cfg_r;
  logic                s1_valid_r, s1_valid_nxt;
  logic [SET_W-1:0]    s1_set_r;
  logic [TAG_BITS-1:0] s1_tag_r;
  logic [SETS-1:0]     set_vld_r, set_vld_nxt;
  logic                fwd_en_r, fwd_en_nxt;
  logic [SET_W-1:0]    fwd_set_r;
  row_t                fwd_row_r;
  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r;
  logic [WAY_W-1:0]    out_way_r;
  logic [TAG_BITS-1:0] out_evicted_r;

  logic                in_fire;
  logic                s1_adv;
  logic                mem_we;
  logic [ROW_W-1:0]    mem_rdata;
  row_t                row_cur;
  row_t                new_row;
  lk_result_t          res;

  // Handshake: a new request enters whenever the lookup stage moves on or is empty.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign mem_we      = s1_adv && res.wr;

  // Row memory: one row per set, read on accept, written back in the lookup stage.
  sacf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_set_r),
    .wdata (new_row),
    .re    (in_fire),
    .raddr (in_ch.set_index[SET_W-1:0]),
    .rdata (mem_rdata)
  );

  // The forwarding register always holds the latest row written, so it is current for its set.
  assign row_cur = (fwd_en_r && (fwd_set_r == s1_set_r)) ? fwd_row_r : row_t'(mem_rdata);

  sacf_lookup u_lookup (
    .row      (row_cur),
    .row_ok   (set_vld_r[s1_set_r]),
    .tag      (s1_tag_r),
    .ways_cfg (ways_cfg_r),
    .res      (res),
    .new_row  (new_row)
  );

  // Next-state logic for the control registers.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    set_vld_nxt   = set_vld_r;
    fwd_en_nxt    = fwd_en_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      s1_valid_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
    if (mem_we) begin
      set_vld_nxt[s1_set_r] = 1'b1;
      fwd_en_nxt            = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_cfg_r  <= WAYS_RESET;
      s1_valid_r  <= 1'b0;
      set_vld_r   <= '0;
      fwd_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ways_cfg_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      set_vld_r   <= set_vld_nxt;
      fwd_en_r    <= fwd_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers of the lookup stage, the forwarding path and the result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_set_r <= in_ch.set_index[SET_W-1:0];
      s1_tag_r <= in_ch.access_tag[TAG_BITS-1:0];
    end
    if (mem_we) begin
      fwd_set_r <= s1_set_r;
      fwd_row_r <= new_row;
    end
    if (s1_adv) begin
      out_kind_r    <= res.kind;
      out_way_r     <= res.way;
      out_evicted_r <= res.evicted;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.access_kind = out_kind_r;
  assign out_ch.way_used    = WAY_FIELD_W'(out_way_r);
  assign out_ch.evicted_tag = TAG_FIELD_W'(out_evicted_r);

endmodule

// ===== rtl/sacf_checker.sv =====
// Port-level checks on the tag store and the bind that attaches them to the top level.
// Depends on sacf_pkg for the result codes and on set_assoc_cache_fifo_lookup.
module sacf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [sacf_pkg::KIND_FIELD_W-1:0] out_kind,
  input logic [sacf_pkg::TAG_FIELD_W-1:0]  out_evicted
);
  import sacf_pkg::*;

  // A result that is not taken stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // Only a conflict miss reports an evicted tag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_EVICT) |-> (out_evicted == '0))
    else $error("evicted tag non-zero on a hit or fill");

  // The block turns requests away only while a result is held back.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("request refused while the result path is free");

  // No result is offered straight after reset.
  assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

  // A result that is held back keeps its kind and evicted tag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_evicted))
    else $error("result payload changed while it was held");

endmodule

bind set_assoc_cache_fifo_lookup sacf_checker u_sacf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.access_kind),
  .out_evicted (out_ch.evicted_tag)
);
